>>> sv/bblur_pkg.sv
// Shared types, constants and the reciprocal table for the 3x3 box blur.
// No dependencies; used by bblur_cell and the top level.
package bblur_pkg;

   localparam int NUM_CHAN    = 3;
   localparam int CHAN_W      = 8;
   localparam int PIXEL_W     = NUM_CHAN * CHAN_W;
   localparam int NUM_CELLS   = 3;
   localparam int COL_SUM_W   = 10;   // three pixels of one channel
   localparam int WIN_SUM_W   = 12;   // nine pixels of one channel
   localparam int COUNT_W     = 4;    // in-frame neighbors, 1..9
   localparam int DIVIDEND_W  = 13;   // 2*sum + count
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 18;
   localparam int PROD_W      = DIVIDEND_W + RECIP_W;

   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 13;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // channel 0 is red, in the low byte
   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0]    pixel_type;
   typedef logic [NUM_CHAN-1:0][COL_SUM_W-1:0] col_sum_type;

   // one window column: row above, own row, row below of the output pixel
   typedef struct packed {
      pixel_type top;
      pixel_type middle;
      pixel_type bottom;
   } column_type;

   // which neighbors of the output pixel lie inside the frame
   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
   } nbr_mask_type;

   // ceil(2^17 / n): floor(x / 2n) == (x * recip(n)) >> 18 for x below 2^13
   function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] n);
      logic [RECIP_W-1:0] m;
      unique case (n)
         4'd1:    m = 18'd131072;
         4'd2:    m = 18'd65536;
         4'd3:    m = 18'd43691;
         4'd4:    m = 18'd32768;
         4'd5:    m = 18'd26215;
         4'd6:    m = 18'd21846;
         4'd7:    m = 18'd18725;
         4'd8:    m = 18'd16384;
         4'd9:    m = 18'd14564;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

>>> sv/bblur_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bblur_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bblur_cell.sv
// One column cell of the 3x3 window chain: holds three pixels, passes them
// to its neighbor on each shift and gives its masked column sum.
// Depends on bblur_pkg.
module bblur_cell (
   input  logic                    clock,
   input  logic                    shift_en,
   input  bblur_pkg::column_type   shift_data,
   input  bblur_pkg::nbr_mask_type mask,
   output bblur_pkg::column_type   col_out,
   output bblur_pkg::col_sum_type  col_sum,
   output logic [1:0]              rows_used
);
   import bblur_pkg::*;

   column_type col_ff;
   column_type col_in;

   assign col_in = shift_en ? shift_data : col_ff;

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end

   always_comb begin
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         col_sum[ch] = COL_SUM_W'(col_ff.middle[ch])
                     + (mask.top    ? COL_SUM_W'(col_ff.top[ch])    : '0)
                     + (mask.bottom ? COL_SUM_W'(col_ff.bottom[ch]) : '0);
      end
   end

   assign rows_used = 2'd1 + 2'(mask.top) + 2'(mask.bottom);
   assign col_out   = col_ff;

endmodule

>>> sv/box_blur_three_by_three.sv
// 3x3 box blur of an RGB raster stream; top level.
// Depends on bblur_pkg, bblur_ram and bblur_cell.
//
// Pixels enter on req_ (tuser = command: pixel or drain tick), results leave
// on rsp_ with tlast on the frame's final pixel. A result belongs to the pixel
// frame_width+1 words earlier; after a frame, frame_width+1 drain words flush
// the rest. Each output channel is the rounded-half-up mean of the in-frame
// neighbors. csr_ writes frame_width (index 0) or frame_height (index 1) and
// restarts the frame; csr_ready is always high.
// Sequence: the sequencer steps through row store read, window shift, window
// sum, reciprocal multiply and the rsp_ register load for one word at a time;
// a word with no result ends after the window shift, and an ignored drain is
// only accepted. A new word is accepted once the previous one is through.
// Reset: counters cleared, size registers at 640x480; the row stores are not
// cleared (their stale entries only feed out-of-frame neighbors).
// Stall: a result waits in the rsp_ register; the next word is accepted and
// processed meanwhile, and holds in the last step until the register frees.
module box_blur_three_by_three #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [bblur_pkg::PIXEL_W-1:0]    req_tdata,   // red_in, green_in, blue_in
   input  logic                             req_tuser,   // command
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [bblur_pkg::PIXEL_W-1:0]    rsp_tdata,   // red_out, green_out, blue_out
   output logic                             rsp_tlast,   // frame_end
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bblur_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bblur_pkg::CSR_DATA_W-1:0] csr_data
);
   import bblur_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 2);
   localparam int RW = $clog2(MAX_HEIGHT + 3);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_SUM  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   // ---------------- configuration ----------------
   logic [FRAME_WIDTH_W-1:0]  width_ff, width_in;
   logic [FRAME_HEIGHT_W-1:0] height_ff, height_in;
   logic                      csr_write, csr_hit;
   logic [WW-1:0]             w_c;
   logic [RW-1:0]             h_c;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign csr_hit   = csr_write
                      && (csr_index == CSR_FRAME_WIDTH || csr_index == CSR_FRAME_HEIGHT);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write && csr_index == CSR_FRAME_WIDTH) begin
         width_in = csr_data[FRAME_WIDTH_W-1:0];
      end
      if (csr_write && csr_index == CSR_FRAME_HEIGHT) begin
         height_in = csr_data[FRAME_HEIGHT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FRAME_WIDTH_RESET;
         height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // zero counts as one, large values saturate
   always_comb begin
      priority if (width_ff == '0) begin
         w_c = WW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_c = WW'(MAX_WIDTH);
      end else begin
         w_c = WW'(width_ff);
      end
      priority if (height_ff == '0) begin
         h_c = RW'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_c = RW'(MAX_HEIGHT);
      end else begin
         h_c = RW'(height_ff);
      end
   end

   // ---------------- position counters ----------------
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] col_ff, col_in, cur_col, ncol;
   logic [RW-1:0] row_ff, row_in, cur_row, nrow;
   logic [WW-1:0] lag_ff, lag_in, cur_lag, nlag;        // input words up to w+1
   logic [CW-1:0] ocol_ff, ocol_in, cur_ocol, nocol;    // output pixel position
   logic [RW-1:0] orow_ff, orow_in, cur_orow, norow;
   logic [WW-1:0] pending_ff, pending_in, pend_dec, pend_set;
   logic [WW-1:0] col_next_w, ocol_next_w;
   logic          accept, is_drain, restart, ignore, started, col_wrap, ocol_wrap;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_drain   = (req_tuser == CMD_DRAIN);
   assign restart    = !is_drain && (pending_ff != '0);
   assign ignore     = is_drain && (pending_ff == '0);

   // a pixel arriving while a drain is owed starts a new frame
   assign cur_col  = restart ? '0 : col_ff;
   assign cur_row  = restart ? '0 : row_ff;
   assign cur_lag  = restart ? '0 : lag_ff;
   assign cur_ocol = restart ? '0 : ocol_ff;
   assign cur_orow = restart ? '0 : orow_ff;

   assign started     = (cur_lag == w_c + WW'(1));
   assign col_next_w  = WW'(cur_col) + WW'(1);
   assign col_wrap    = (col_next_w >= w_c);
   assign ncol        = col_wrap ? '0 : col_next_w[CW-1:0];
   assign nrow        = col_wrap ? cur_row + RW'(1) : cur_row;
   assign nlag        = started ? cur_lag : cur_lag + WW'(1);
   assign ocol_next_w = WW'(cur_ocol) + WW'(1);
   assign ocol_wrap   = (ocol_next_w >= w_c);
   assign nocol       = !started ? cur_ocol : (ocol_wrap ? '0 : ocol_next_w[CW-1:0]);
   assign norow       = (started && ocol_wrap) ? cur_orow + RW'(1) : cur_orow;
   assign pend_dec    = pending_ff - WW'(1);
   assign pend_set    = (col_wrap && nrow == h_c) ? w_c + WW'(1) : '0;

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      lag_in     = lag_ff;
      ocol_in    = ocol_ff;
      orow_in    = orow_ff;
      pending_in = pending_ff;
      priority if (csr_hit) begin
         col_in     = '0;
         row_in     = '0;
         lag_in     = '0;
         ocol_in    = '0;
         orow_in    = '0;
         pending_in = '0;
      end else if (accept && !ignore) begin
         if (is_drain && pend_dec == '0) begin
            col_in     = '0;
            row_in     = '0;
            lag_in     = '0;
            ocol_in    = '0;
            orow_in    = '0;
            pending_in = '0;
         end else begin
            col_in     = ncol;
            row_in     = nrow;
            lag_in     = nlag;
            ocol_in    = nocol;
            orow_in    = norow;
            pending_in = is_drain ? pend_dec : pend_set;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         lag_ff     <= '0;
         ocol_ff    <= '0;
         orow_ff    <= '0;
         pending_ff <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         lag_ff     <= lag_in;
         ocol_ff    <= ocol_in;
         orow_ff    <= orow_in;
         pending_ff <= pending_in;
      end
   end

   // ---------------- per-word latch ----------------
   pixel_type    px_ff, px_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic         produce_ff, produce_in;
   logic         end_ff, end_in;
   nbr_mask_type mask_ff, mask_in;
   logic         take;

   assign take = accept && !ignore;

   always_comb begin
      px_in      = px_ff;
      addr_in    = addr_ff;
      produce_in = produce_ff;
      end_in     = end_ff;
      mask_in    = mask_ff;
      if (take) begin
         px_in          = is_drain ? '0 : pixel_type'(req_tdata);
         addr_in        = cur_col;
         produce_in     = started && (cur_orow < h_c);
         end_in         = (cur_orow == h_c - RW'(1)) && (WW'(cur_ocol) == w_c - WW'(1));
         mask_in.top    = (cur_orow != '0);
         mask_in.bottom = (cur_orow + RW'(1)) < h_c;
         mask_in.left   = (cur_ocol != '0);
         mask_in.right  = ocol_next_w < w_c;
      end
   end

   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      addr_ff <= addr_in;
      end_ff  <= end_in;
      mask_ff <= mask_in;
      if (reset) begin
         produce_ff <= 1'b0;
      end else begin
         produce_ff <= produce_in;
      end
   end

   // ---------------- row stores ----------------
   logic [PIXEL_W-1:0] prev_rd, prev2_rd;
   logic               store_wr;

   assign store_wr = (state_ff == S_LOAD);

   bblur_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (addr_ff),
      .wr_data (px_ff),
      .rd_en   (take),
      .rd_addr (cur_col),
      .rd_data (prev_rd)
   );

   // the older row takes what the newer one held at this column
   bblur_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
   ) u_prev2_ram (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (addr_ff),
      .wr_data (prev_rd),
      .rd_en   (take),
      .rd_addr (cur_col),
      .rd_data (prev2_rd)
   );

   // ---------------- window chain ----------------
   column_type  cell_in   [NUM_CELLS];
   column_type  cell_out  [NUM_CELLS];
   col_sum_type cell_sum  [NUM_CELLS];
   logic [1:0]  cell_rows [NUM_CELLS];

   assign cell_in[NUM_CELLS-1].top    = pixel_type'(prev2_rd);
   assign cell_in[NUM_CELLS-1].middle = pixel_type'(prev_rd);
   assign cell_in[NUM_CELLS-1].bottom = px_ff;

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      if (k < NUM_CELLS - 1) begin : g_link
         assign cell_in[k] = cell_out[k+1];
      end
      bblur_cell u_cell (
         .clock      (clock),
         .shift_en   (store_wr),
         .shift_data (cell_in[k]),
         .mask       (mask_ff),
         .col_out    (cell_out[k]),
         .col_sum    (cell_sum[k]),
         .rows_used  (cell_rows[k])
      );
   end

   // ---------------- sum, divide ----------------
   logic [NUM_CHAN-1:0][WIN_SUM_W-1:0]  win_sum;
   logic [COUNT_W-1:0]                  win_count;
   logic [NUM_CHAN-1:0][DIVIDEND_W-1:0] dividend_ff, dividend_in;
   logic [RECIP_W-1:0]                  recip_ff, recip_in;
   logic [NUM_CHAN-1:0][PROD_W-1:0]     prod_ff, prod_in;

   always_comb begin
      win_count = (mask_ff.left ? COUNT_W'(cell_rows[0]) : '0)
                + COUNT_W'(cell_rows[1])
                + (mask_ff.right ? COUNT_W'(cell_rows[2]) : '0);
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         win_sum[ch] = (mask_ff.left ? WIN_SUM_W'(cell_sum[0][ch]) : '0)
                     + WIN_SUM_W'(cell_sum[1][ch])
                     + (mask_ff.right ? WIN_SUM_W'(cell_sum[2][ch]) : '0);
         dividend_in[ch] = (state_ff == S_SUM)
                         ? {win_sum[ch], 1'b0} + DIVIDEND_W'(win_count)
                         : dividend_ff[ch];
         prod_in[ch] = (state_ff == S_MUL)
                     ? PROD_W'(dividend_ff[ch]) * PROD_W'(recip_ff)
                     : prod_ff[ch];
      end
      recip_in = (state_ff == S_SUM) ? recip(win_count) : recip_ff;
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      recip_ff    <= recip_in;
      prod_ff     <= prod_in;
   end

   // ---------------- output register ----------------
   logic      rsp_valid_ff, rsp_valid_in;
   pixel_type rsp_data_ff, rsp_data_in;
   logic      rsp_last_ff, rsp_last_in;
   logic      out_free, load_out;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load_out = (state_ff == S_OUT) && out_free;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      if (load_out) begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            rsp_data_in[ch] = prod_ff[ch][RECIP_SHIFT +: CHAN_W];
         end
         rsp_last_in = end_ff;
      end
      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = produce_ff ? S_SUM : S_IDLE;
         end
         S_SUM: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTH
   a_word_before_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |-> $past(req_tvalid && req_tready))
      else $error("window shift without an accepted word");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == S_OUT))
      else $error("result word raised outside the output step");

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < w_c)
      else $error("column counter beyond frame width");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= w_c + WW'(1))
      else $error("drain count beyond frame width plus one");
`endif

endmodule
